### hw/rtl/sha1_pkg.sv
// ============================================================================
// SHA-1 package
// Shared types and constants for the SHA-1 hash engine.
// ============================================================================
`default_nettype none

package sha1_pkg;

    localparam logic OP_ABSORB = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;

    localparam logic [31:0] H0 = 32'h67452301;
    localparam logic [31:0] H1 = 32'hEFCDAB89;
    localparam logic [31:0] H2 = 32'h98BADCFE;
    localparam logic [31:0] H3 = 32'h10325476;
    localparam logic [31:0] H4 = 32'hC3D2E1F0;

    // One queued word between the front and back parts.
    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_word;

endpackage

`default_nettype wire

### hw/rtl/sha1_hash_engine.sv
// ============================================================================
// SHA-1 hash engine
// Top level: input queue in front of the compression back end.
// ============================================================================
// Each absorbed byte is stored into the block by the back end; every 64th byte
// starts an 80-round compression at one round per cycle, then the final add.
// A finish word pads, compresses one or two blocks, then offers 20 digest
// bytes one per cycle while i_stall is low.
// A four-word input queue lets bytes arrive while a block is compressed.
`default_nettype none

module sha1_hash_engine
    import sha1_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_stall,
    input  wire        i_op,
    input  wire  [7:0] i_data_byte,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_digest_byte,
    output logic       o_last
);

    logic  q_valid;
    t_word q_word;
    logic  q_pop;

    sha1_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_op(i_op), .i_data_byte(i_data_byte),
        .o_q_valid(q_valid), .o_q_word(q_word), .i_q_pop(q_pop)
    );

    sha1_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .i_q_word(q_word), .o_q_pop(q_pop),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_byte(o_digest_byte), .o_last(o_last)
    );

endmodule

`default_nettype wire

### hw/rtl/sha1_front.sv
// ============================================================================
// SHA-1 front queue
// Accepts input words and holds them in a short queue for the back part.
// ============================================================================
`default_nettype none

module sha1_front
    import sha1_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_valid,
    output logic  o_stall,
    input  wire   i_op,
    input  wire   [7:0] i_data_byte,
    output logic  o_q_valid,
    output t_word o_q_word,
    input  wire   i_q_pop
);

    t_word      r_mem [4];
    logic [1:0] r_wp;
    logic [1:0] r_rp;
    logic [2:0] r_cnt;
    logic       push;
    logic       pop;

    assign o_stall   = (r_cnt == 3'd4);
    assign push      = i_valid && !o_stall;
    assign o_q_valid = (r_cnt != 3'd0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_word  = r_mem[r_rp];

    // Queue storage.
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= '{op: i_op, data: i_data_byte};
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 2'd1;
            if (pop)  r_rp <= r_rp + 2'd1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sha1_back.sv
// ============================================================================
// SHA-1 back end
// Collects bytes, pads, runs 80 rounds per block and emits the digest.
// ============================================================================
`default_nettype none

module sha1_back
    import sha1_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_q_valid,
    input  wire t_word i_q_word,
    output logic       o_q_pop,
    output logic       o_valid,
    input  wire        i_stall,
    output logic [7:0] o_digest_byte,
    output logic       o_last
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROUND = 3'd1;
    localparam logic [2:0] S_ADD   = 3'd2;
    localparam logic [2:0] S_PAD   = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]   r_state, n_state;
    logic [511:0] r_blk;
    logic [5:0]   r_cnt;
    logic [63:0]  r_bits;
    logic [31:0]  r_h [5];
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_rnd;
    logic         r_fin;
    logic         r_len_done;
    logic         r_spill;
    logic [4:0]   r_oidx;
    logic [159:0] r_dig;

    logic [31:0]  w, f, k, t;
    logic [63:0]  len;
    logic         len_fits;

    // Round function; schedule word sits at the top of the block shifter.
    always_comb begin
        w = r_blk[511:480];
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d);
            k = K0;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d;
            k = K1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            k = K2;
        end else begin
            f = r_b ^ r_c ^ r_d;
            k = K3;
        end
        t        = {r_a[26:0], r_a[31:27]} + f + r_e + k + w;
        len      = r_bits + {55'd0, r_cnt, 3'd0};
        len_fits = r_spill || (r_cnt < 6'd56);
    end

    assign o_q_pop       = (r_state == S_IDLE) && i_q_valid;
    assign o_valid       = (r_state == S_OUT);
    assign o_digest_byte = r_dig[159:152];
    assign o_last        = (r_oidx == 5'd19);

    logic [31:0] wn;
    assign wn = r_blk[511-13*32 -: 32] ^ r_blk[511-8*32 -: 32]
              ^ r_blk[511-2*32 -: 32] ^ r_blk[511:480];

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_q_valid && i_q_word.op == OP_FINISH) n_state = S_PAD;
                     else if (i_q_valid && r_cnt == 6'd63) n_state = S_ROUND;
            S_PAD:   n_state = S_ROUND;
            S_ROUND: if (r_rnd == 7'd79) n_state = S_ADD;
            S_ADD:   if (!r_fin) n_state = S_IDLE;
                     else if (r_len_done) n_state = S_OUT;
                     else n_state = S_PAD;
            S_OUT:   if (!i_stall && r_oidx == 5'd19) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_bits  <= '0;
            r_fin   <= 1'b0;
            r_len_done <= 1'b0;
            r_spill <= 1'b0;
            r_oidx  <= '0;
            r_rnd   <= '0;
            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2; r_h[3] <= H3; r_h[4] <= H4;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_q_valid && i_q_word.op == OP_ABSORB) begin
                        r_blk[511 - 8*r_cnt -: 8] <= i_q_word.data;
                        r_cnt <= r_cnt + 6'd1;
                        r_fin <= 1'b0;
                        if (r_cnt == 6'd63) r_bits <= r_bits + 64'd512;
                    end else if (i_q_valid) begin
                        r_fin      <= 1'b1;
                        r_len_done <= 1'b0;
                        r_spill    <= 1'b0;
                    end
                    r_rnd <= '0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                end
                S_PAD: begin
                    // First pad pass writes 0x80 and zeros; a second pass only zeros.
                    // The bit length fills the last eight bytes once it fits.
                    for (int i = 0; i < 64; i++) begin
                        if (len_fits && i >= 56)
                            r_blk[511 - 8*i -: 8] <= len[8*(63-i) +: 8];
                        else if (!r_spill && i == r_cnt)
                            r_blk[511 - 8*i -: 8] <= PAD_BYTE;
                        else if (r_spill || i > r_cnt)
                            r_blk[511 - 8*i -: 8] <= 8'h00;
                    end
                    if (len_fits) begin
                        r_len_done <= 1'b1;
                    end else begin
                        r_len_done <= 1'b0;
                        r_spill    <= 1'b1;
                        r_cnt      <= 6'd0;
                        r_bits     <= len;
                    end
                    r_rnd <= '0;
                    r_a <= r_h[0]; r_b <= r_h[1]; r_c <= r_h[2];
                    r_d <= r_h[3]; r_e <= r_h[4];
                end
                S_ROUND: begin
                    r_e <= r_d;
                    r_d <= r_c;
                    r_c <= {r_b[1:0], r_b[31:2]};
                    r_b <= r_a;
                    r_a <= t;
                    r_rnd <= r_rnd + 7'd1;
                    r_blk <= {r_blk[479:0], wn[30:0], wn[31]};
                end
                S_ADD: begin
                    r_h[0] <= r_h[0] + r_a; r_h[1] <= r_h[1] + r_b;
                    r_h[2] <= r_h[2] + r_c; r_h[3] <= r_h[3] + r_d;
                    r_h[4] <= r_h[4] + r_e;
                    r_dig  <= {r_h[0] + r_a, r_h[1] + r_b, r_h[2] + r_c,
                               r_h[3] + r_d, r_h[4] + r_e};
                    r_oidx <= '0;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_dig  <= {r_dig[151:0], 8'h00};
                        r_oidx <= r_oidx + 5'd1;
                        if (r_oidx == 5'd19) begin
                            r_h[0] <= H0; r_h[1] <= H1; r_h[2] <= H2;
                            r_h[3] <= H3; r_h[4] <= H4;
                            r_cnt  <= '0;
                            r_bits <= '0;
                            r_fin  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

`default_nettype wire

### hw/rtl/sha1_checker.sv
// ============================================================================
// SHA-1 port checker
// Checks handshake behavior seen at the top-level ports.
// ============================================================================
`default_nettype none

module sha1_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       o_stall,
    input wire       o_valid,
    input wire       i_stall,
    input wire [7:0] o_digest_byte,
    input wire       o_last
);

    // A stalled digest word holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_digest_byte) && $stable(o_last))
        else $error("digest word changed under stall");

    // After the last word is taken, no digest is offered next cycle.
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid)
        else $error("output after last word");

    // Reset clears the output side.
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs active after reset");

endmodule

bind sha1_hash_engine sha1_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_digest_byte(o_digest_byte),
    .o_last(o_last)
);

`default_nettype wire
